// ===== rtl/emg_pkg.sv =====
// Package for the multi-stage envelope generator: step count, opcodes, register
// indexes, phase and sequencer types, reset values and the reset level table.
// Depends on nothing; used by the top level and by the RAM instance parameters.
package emg_pkg;

    localparam int NUM_STEPS = 16;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int ENTRY_W   = 16;

    // Input opcodes, carried in tuser.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_SYNC    = 3'd3;
    localparam logic [2:0] OP_WRITE   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROFFS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd5;

    // Mode bit positions.
    localparam int MODE_SYNC    = 0;
    localparam int MODE_ONESHOT = 1;
    localparam int MODE_FAST    = 2;
    localparam int MODE_JUMP    = 3;

    localparam logic [15:0] LEVEL_MAX   = 16'hFF00;
    localparam logic [7:0]  RESET_DUR   = 8'd20;
    localparam logic [4:0]  RESET_SUS   = 5'd8;
    localparam logic [3:0]  RESET_LAST  = 4'd15;
    localparam logic [7:0]  RESET_SPEED = 8'd2;

    // State after reset of the ramp registers, as the first recompute leaves it.
    localparam logic [STEP_W-1:0] RESET_NEXT  = STEP_W'(1);
    localparam logic [16:0]       RESET_LIMIT = 17'd20;
    localparam logic [17:0]       RESET_INC   = 18'd409;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_RELEASE = 2'd2,
        PH_SUSTAIN = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAIN,
        ST_SUS_WB,
        ST_ADV_WB,
        ST_RAMP_WB,
        ST_RC_NX,
        ST_RC_CUR,
        ST_RC_DUR,
        ST_RC_LIM,
        ST_RC_DIV0,
        ST_DIV,
        ST_DIV_END,
        ST_MUL,
        ST_OUT
    } t_state;

    localparam int LEVEL_STEP = 512 / NUM_STEPS;
    localparam int HALF_STEPS = NUM_STEPS / 2;

    // Level of a step before it is first written: a ramp up, then down.
    function automatic logic [7:0] rst_level(input logic [STEP_W-1:0] idx);
        logic [9:0] up;
        logic [9:0] down;
        begin
            up   = 10'(idx) * 10'(LEVEL_STEP);
            down = 10'd255 - (10'(idx) - 10'(HALF_STEPS)) * 10'(LEVEL_STEP);
            rst_level = (32'(idx) < HALF_STEPS) ? up[7:0] : down[7:0];
        end
    endfunction

endpackage

// ===== rtl/emg_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; the contents are undefined until written.
module emg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/multi_stage_envelope_generator.sv =====
// Multi-stage envelope generator: step table in a RAM, ramp sequencer, serial
// divider for the ramp increment and the output gain stage.
// Depends on emg_pkg and emg_ram.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: step fields, mods; tuser: opcode
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: env_value; tuser: sustain_entered
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Restart, release, sync and write-step items are handled in the idle state.
// A tick runs at most two ramp recomputes, one for a pending restart or release and
// one on a step change; each recompute runs the 16-step restoring divider. The step
// table sits in one RAM whose single read port is used in turn by the sequencer.
// Reset is synchronous; a finished result waits in the output register, and the
// next item is accepted meanwhile; a tick stalls only when it has a new result.
module multi_stage_envelope_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] step_index, [11:4] step_level, [19:12] step_duration,
    // [35:20] amp_mod, [51:36] rate_mod, [55:52] zero
    input  logic [55:0] s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] env_value, [23:17] zero
    output logic [23:0] m_axis_tdata,
    // [0] sustain_entered
    output logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int SW = emg_pkg::STEP_W;

    // Configuration registers.
    logic [4:0]        r_sustain;
    logic [3:0]        r_last;
    logic signed [7:0] r_roffs;
    logic signed [7:0] r_amp;
    logic [3:0]        r_mode;
    logic [7:0]        r_speed;

    // Envelope state.
    emg_pkg::t_state   r_state, n_state;
    emg_pkg::t_phase   r_phase;
    logic [SW-1:0]     r_cur_step;
    logic [SW-1:0]     r_next_step;
    logic [15:0]       r_level_cnt;
    logic [16:0]       r_delay_cnt;
    logic [16:0]       r_delay_limit;
    logic signed [17:0] r_increment;
    logic              r_pend_restart;
    logic              r_pend_release;
    logic              r_pend_sync;
    logic              r_entered;
    logic              r_ret_main;
    logic [emg_pkg::NUM_STEPS-1:0] r_valid;

    // Per-tick payload.
    logic signed [15:0] r_amod;
    logic signed [15:0] r_rmod;
    logic [15:0]        r_target;
    logic [10:0]        r_dur_adj;

    // Divider.
    logic [16:0]                   r_divisor;
    logic [16:0]                   r_rem;
    logic [emg_pkg::DIV_W-1:0]     r_quo;
    logic [emg_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                          r_div_neg;
    logic                          r_diff_pos;

    // Output.
    logic signed [24:0] r_product;
    logic               r_out_valid;
    logic [16:0]        r_out_env;
    logic               r_out_sus;

    // RAM read side.
    logic [SW-1:0]                  ram_raddr;
    logic [emg_pkg::ENTRY_W-1:0]    ram_rdata;
    logic [SW-1:0]                  r_rd_addr;
    logic                           r_rd_valid;
    logic [7:0]                     rd_level;
    logic [7:0]                     rd_dur;
    logic                           ram_we;

    logic in_acc;
    logic is_tick;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign is_tick = (s_axis_tuser == emg_pkg::OP_TICK);
    assign ram_we  = in_acc && (s_axis_tuser == emg_pkg::OP_WRITE);

    emg_ram #(
        .WIDTH (emg_pkg::ENTRY_W),
        .DEPTH (emg_pkg::NUM_STEPS)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_axis_tdata[SW-1:0]),
        .i_wdata ({s_axis_tdata[19:12], s_axis_tdata[11:4]}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // An entry never written reads as its reset value.
    always_comb begin
        if (r_rd_valid) begin
            rd_level = ram_rdata[7:0];
            rd_dur   = ram_rdata[15:8];
        end else begin
            rd_level = emg_pkg::rst_level(r_rd_addr);
            rd_dur   = emg_pkg::RESET_DUR;
        end
    end

    // Step selection helpers.
    logic          sus_valid;
    logic [4:0]    sus_sel;
    logic [SW-1:0] sus_hold;
    logic [SW:0]   nx_inc;
    logic [SW-1:0] nx_step;
    logic          sync_wait;
    logic [16:0]   cnt_inc;
    logic          enter_sus;

    assign sus_valid = (r_sustain != 5'd0) && (r_sustain <= 5'(emg_pkg::NUM_STEPS));

    always_comb begin
        sus_sel = (r_sustain == 5'd0) ? 5'(emg_pkg::NUM_STEPS - 1) : r_sustain - 5'd1;
        if (sus_sel >= 5'(emg_pkg::NUM_STEPS)) begin
            sus_sel = 5'(emg_pkg::NUM_STEPS - 1);
        end
        sus_hold = sus_sel[SW-1:0];
    end

    always_comb begin
        nx_inc = {1'b0, r_cur_step} + (SW+1)'(1);
        if (nx_inc >= (SW+1)'(emg_pkg::NUM_STEPS) || nx_inc > (SW+1)'(r_last)) begin
            nx_step = r_mode[emg_pkg::MODE_ONESHOT] ? r_cur_step : '0;
        end else begin
            nx_step = nx_inc[SW-1:0];
        end
    end

    assign sync_wait = r_mode[emg_pkg::MODE_SYNC] && !r_pend_sync;
    assign cnt_inc   = r_delay_cnt + 17'd1;
    assign enter_sus = (r_sustain != 5'd0 && {1'b0, r_cur_step} == r_sustain - 5'd1) ||
                       (r_last < 4'(emg_pkg::NUM_STEPS - 1) && 4'(r_cur_step) == r_last);

    // Duration adjust: rate_mod / 128 truncated toward zero.
    logic signed [16:0] rmod_adj;
    logic signed [9:0]  rmod_q;
    logic signed [11:0] dur_raw;
    logic [10:0]        dur_clamp;
    logic [18:0]        dur_prod;

    always_comb begin
        rmod_adj = 17'(r_rmod) + (r_rmod[15] ? 17'sd127 : 17'sd0);
        rmod_q   = rmod_adj[16:7];
        dur_raw  = $signed({4'b0, rd_dur}) - 12'(r_roffs) + 12'(rmod_q);
        if (dur_raw > 12'sd1024) begin
            dur_clamp = 11'd1024;
        end else if (dur_raw < 12'sd1) begin
            dur_clamp = 11'd1;
        end else begin
            dur_clamp = dur_raw[10:0];
        end
        dur_prod = 19'(r_dur_adj) * 19'(r_speed);
    end

    // Divider operands and step.
    logic signed [16:0] diff;
    logic [17:0]        div_trial;
    logic               div_bit;
    logic [emg_pkg::DIV_W-1:0] quo_inc;

    always_comb begin
        diff      = $signed({1'b0, r_target}) - $signed({1'b0, r_level_cnt});
        div_trial = {r_rem, r_quo[emg_pkg::DIV_W-1]};
        div_bit   = (div_trial >= {1'b0, r_divisor});
        quo_inc   = r_quo;
    end

    // Ramp toward the target, clamped at it.
    logic [15:0]        ramp_target;
    logic signed [18:0] ramp_sum;
    logic [15:0]        ramp_next;

    always_comb begin
        ramp_target = {rd_level, 8'h00};
        ramp_sum    = $signed({3'b0, r_level_cnt}) + 19'(r_increment);
        ramp_next   = ramp_sum[15:0];
        if (!r_increment[17] && r_increment != 18'sd0) begin
            if (ramp_sum > $signed({3'b0, ramp_target})) begin
                ramp_next = ramp_target;
            end
        end else begin
            if (ramp_sum < $signed({3'b0, ramp_target})) begin
                ramp_next = ramp_target;
            end
        end
    end

    // Gain: amplitude plus amp_mod / 512, saturated to eight bits.
    logic signed [16:0] amod_adj;
    logic signed [7:0]  amod_q;
    logic signed [8:0]  gain_sum;
    logic signed [7:0]  gain;
    logic signed [24:0] prod_adj;

    always_comb begin
        amod_adj = 17'(r_amod) + (r_amod[15] ? 17'sd511 : 17'sd0);
        amod_q   = amod_adj[16:9];
        gain_sum = 9'(r_amp) + 9'(amod_q);
        if (gain_sum > 9'sd127) begin
            gain = 8'sd127;
        end else if (gain_sum < -9'sd128) begin
            gain = -8'sd128;
        end else begin
            gain = gain_sum[7:0];
        end
        prod_adj = r_product + (r_product[24] ? 25'sd127 : 25'sd0);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            emg_pkg::ST_IDLE: begin
                if (in_acc && is_tick) begin
                    n_state = (r_pend_restart || r_pend_release) ? emg_pkg::ST_RC_NX
                                                                 : emg_pkg::ST_MAIN;
                end
            end
            emg_pkg::ST_MAIN: begin
                if (sync_wait) begin
                    n_state = (r_phase == emg_pkg::PH_IDLE) ? emg_pkg::ST_IDLE
                                                            : emg_pkg::ST_MUL;
                end else if (r_phase == emg_pkg::PH_SUSTAIN) begin
                    n_state = emg_pkg::ST_SUS_WB;
                end else if (cnt_inc >= r_delay_limit) begin
                    n_state = emg_pkg::ST_ADV_WB;
                end else begin
                    n_state = emg_pkg::ST_RAMP_WB;
                end
            end
            emg_pkg::ST_SUS_WB:  n_state = emg_pkg::ST_MUL;
            emg_pkg::ST_ADV_WB:  n_state = enter_sus ? emg_pkg::ST_MUL : emg_pkg::ST_RC_NX;
            emg_pkg::ST_RAMP_WB: n_state = emg_pkg::ST_MUL;
            emg_pkg::ST_RC_NX:   n_state = emg_pkg::ST_RC_CUR;
            emg_pkg::ST_RC_CUR:  n_state = emg_pkg::ST_RC_DUR;
            emg_pkg::ST_RC_DUR:  n_state = emg_pkg::ST_RC_LIM;
            emg_pkg::ST_RC_LIM:  n_state = emg_pkg::ST_RC_DIV0;
            emg_pkg::ST_RC_DIV0: n_state = emg_pkg::ST_DIV;
            emg_pkg::ST_DIV: begin
                if (r_div_cnt == emg_pkg::DIV_CNT_W'(emg_pkg::DIV_W - 1)) begin
                    n_state = emg_pkg::ST_DIV_END;
                end
            end
            emg_pkg::ST_DIV_END: n_state = r_ret_main ? emg_pkg::ST_MAIN : emg_pkg::ST_MUL;
            emg_pkg::ST_MUL:     n_state = emg_pkg::ST_OUT;
            emg_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = emg_pkg::ST_IDLE;
                end
            end
            default: n_state = emg_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and RAM read address.
    always_comb begin
        s_axis_tready = 1'b0;
        ram_raddr     = r_cur_step;
        unique case (r_state)
            emg_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            emg_pkg::ST_MAIN:  ram_raddr = (r_phase == emg_pkg::PH_SUSTAIN) ? sus_hold
                                                                           : r_next_step;
            emg_pkg::ST_RC_NX: ram_raddr = nx_step;
            default:           ram_raddr = r_cur_step;
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_env};
    assign m_axis_tuser  = r_out_sus;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sustain <= emg_pkg::RESET_SUS;
            r_last    <= emg_pkg::RESET_LAST;
            r_roffs   <= '0;
            r_amp     <= '0;
            r_mode    <= '0;
            r_speed   <= emg_pkg::RESET_SPEED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                emg_pkg::CFG_SUSTAIN: r_sustain <= i_cfg_data[4:0];
                emg_pkg::CFG_LAST:    r_last    <= i_cfg_data[3:0];
                emg_pkg::CFG_ROFFS:   r_roffs   <= i_cfg_data;
                emg_pkg::CFG_AMP:     r_amp     <= i_cfg_data;
                emg_pkg::CFG_MODE:    r_mode    <= i_cfg_data[3:0];
                emg_pkg::CFG_SPEED:   r_speed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Read tracking: the valid bit travels with the registered read data.
    always_ff @(posedge i_clk) begin
        r_rd_addr  <= ram_raddr;
        r_rd_valid <= r_valid[ram_raddr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= emg_pkg::ST_IDLE;
            r_phase        <= emg_pkg::PH_IDLE;
            r_cur_step     <= '0;
            r_next_step    <= emg_pkg::RESET_NEXT;
            r_level_cnt    <= '0;
            r_delay_cnt    <= '0;
            r_delay_limit  <= emg_pkg::RESET_LIMIT;
            r_increment    <= emg_pkg::RESET_INC;
            r_pend_restart <= 1'b0;
            r_pend_release <= 1'b0;
            r_pend_sync    <= 1'b0;
            r_entered      <= 1'b0;
            r_ret_main     <= 1'b0;
            r_valid        <= '0;
            r_div_cnt      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                emg_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        priority case (s_axis_tuser)
                            emg_pkg::OP_TICK: begin
                                r_entered  <= 1'b0;
                                r_ret_main <= 1'b1;
                                // Restart first, then release; one recompute covers both.
                                if (r_pend_release) begin
                                    r_phase <= emg_pkg::PH_RELEASE;
                                    if (sus_valid) begin
                                        r_cur_step <= SW'(r_sustain - 5'd1);
                                    end else if (r_pend_restart) begin
                                        r_cur_step <= '0;
                                    end
                                end else if (r_pend_restart) begin
                                    r_phase    <= emg_pkg::PH_ATTACK;
                                    r_cur_step <= '0;
                                end
                                r_pend_restart <= 1'b0;
                                r_pend_release <= 1'b0;
                            end
                            emg_pkg::OP_RESTART: r_pend_restart <= 1'b1;
                            emg_pkg::OP_RELEASE: r_pend_release <= 1'b1;
                            emg_pkg::OP_SYNC:    r_pend_sync    <= 1'b1;
                            emg_pkg::OP_WRITE:   r_valid[s_axis_tdata[SW-1:0]] <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                emg_pkg::ST_MAIN: begin
                    if (!sync_wait) begin
                        r_pend_sync <= 1'b0;
                        if (r_phase != emg_pkg::PH_SUSTAIN) begin
                            r_delay_cnt <= cnt_inc;
                            if (cnt_inc >= r_delay_limit) begin
                                r_cur_step <= r_next_step;
                            end
                        end
                    end
                end
                emg_pkg::ST_SUS_WB: r_level_cnt <= {rd_level, 8'h00};
                emg_pkg::ST_ADV_WB: begin
                    r_level_cnt <= {rd_level, 8'h00};
                    if (enter_sus) begin
                        r_phase   <= emg_pkg::PH_SUSTAIN;
                        r_entered <= 1'b1;
                    end else begin
                        r_ret_main <= 1'b0;
                    end
                end
                emg_pkg::ST_RAMP_WB: begin
                    if (r_mode[emg_pkg::MODE_JUMP]) begin
                        r_level_cnt <= ramp_target;
                    end else if (r_level_cnt != ramp_target) begin
                        r_level_cnt <= ramp_next;
                    end
                end
                emg_pkg::ST_RC_NX: r_next_step <= nx_step;
                emg_pkg::ST_RC_LIM: begin
                    r_delay_cnt   <= '0;
                    r_delay_limit <= r_mode[emg_pkg::MODE_FAST] ? {6'b0, r_dur_adj}
                                                                : dur_prod[17:1];
                end
                emg_pkg::ST_RC_DIV0: r_div_cnt <= '0;
                emg_pkg::ST_DIV:     r_div_cnt <= r_div_cnt + emg_pkg::DIV_CNT_W'(1);
                emg_pkg::ST_DIV_END: begin
                    if (quo_inc == '0) begin
                        r_increment <= r_diff_pos ? 18'sd1 : -18'sd1;
                    end else if (r_div_neg) begin
                        r_increment <= -$signed({2'b0, quo_inc});
                    end else begin
                        r_increment <= $signed({2'b0, quo_inc});
                    end
                end
                emg_pkg::ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            emg_pkg::ST_IDLE: begin
                if (in_acc && is_tick) begin
                    r_amod <= s_axis_tdata[35:20];
                    r_rmod <= s_axis_tdata[51:36];
                end
            end
            emg_pkg::ST_RC_CUR: r_target  <= {rd_level, 8'h00};
            emg_pkg::ST_RC_DUR: r_dur_adj <= dur_clamp;
            emg_pkg::ST_RC_DIV0: begin
                r_divisor  <= (r_delay_limit == 17'd0) ? 17'd1 : r_delay_limit;
                r_rem      <= '0;
                r_quo      <= diff[16] ? 16'(-diff) : diff[15:0];
                r_div_neg  <= diff[16];
                r_diff_pos <= !diff[16] && (diff != 17'sd0);
            end
            emg_pkg::ST_DIV: begin
                r_quo <= {r_quo[emg_pkg::DIV_W-2:0], div_bit};
                r_rem <= div_bit ? 17'(div_trial - {1'b0, r_divisor}) : div_trial[16:0];
            end
            emg_pkg::ST_MUL: r_product <= $signed({9'b0, r_level_cnt}) * 25'(gain);
            emg_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    // Division by 128 truncating toward zero.
                    r_out_env <= prod_adj[23:7];
                    r_out_sus <= r_entered;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level_cnt <= emg_pkg::LEVEL_MAX)
        else $error("level counter beyond the top step level");

    a_pend_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == emg_pkg::ST_MAIN) |-> (!r_pend_restart && !r_pend_release))
        else $error("restart or release still pending during a tick");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == emg_pkg::ST_OUT && r_out_valid && !m_axis_tready)
        |=> (r_state == emg_pkg::ST_OUT))
        else $error("tick result overwrote an untaken result");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == emg_pkg::ST_RC_DIV0) |=> (r_state == emg_pkg::ST_DIV && r_div_cnt == '0))
        else $error("divider did not start from its first step");
`endif

endmodule
